>>> sv/sie_pkg.sv
`timescale 1ns / 1ps

package sie_pkg;

    localparam int REG_COUNT    = 16;
    localparam int PC_BITS      = 12;
    localparam int REG_IDX_BITS = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int IDX_IN_BITS  = 4;
    localparam int WORD_BITS    = 32;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_ADDI = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_B    = 4'd5;
    localparam logic [3:0] OP_BEQ  = 4'd6;
    localparam logic [3:0] OP_BNQ  = 4'd7;
    localparam logic [3:0] OP_END  = 4'd8;

    typedef struct packed {
        logic start;
        logic negate;
    } div_ctrl_t;

    // True when a register index names an entry that exists.
    function automatic logic idx_ok(input logic [IDX_IN_BITS-1:0] idx);
        return 32'(idx) < REG_COUNT;
    endfunction

endpackage

>>> sv/sie_regfile.sv
`timescale 1ns / 1ps

module sie_regfile (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [sie_pkg::REG_IDX_BITS-1:0]    rd_addr_a,
    input  logic [sie_pkg::REG_IDX_BITS-1:0]    rd_addr_b,
    output logic [sie_pkg::WORD_BITS-1:0]       rd_data_a,
    output logic [sie_pkg::WORD_BITS-1:0]       rd_data_b,
    input  logic                                wr_en,
    input  logic [sie_pkg::REG_IDX_BITS-1:0]    wr_addr,
    input  logic [sie_pkg::WORD_BITS-1:0]       wr_data
);

    logic [sie_pkg::WORD_BITS-1:0] mem [sie_pkg::REG_COUNT];
    logic [sie_pkg::REG_COUNT-1:0] vld_reg;
    logic [sie_pkg::WORD_BITS-1:0] rdata_a_reg;
    logic [sie_pkg::WORD_BITS-1:0] rdata_b_reg;
    logic                          rvld_a_reg;
    logic                          rvld_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_a_reg <= mem[rd_addr_a];
            rdata_b_reg <= mem[rd_addr_b];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rvld_a_reg <= 1'b0;
            rvld_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_a_reg <= vld_reg[rd_addr_a];
                rvld_b_reg <= vld_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = rvld_a_reg ? rdata_a_reg : '0;
    assign rd_data_b = rvld_b_reg ? rdata_b_reg : '0;

endmodule

>>> sv/sie_divider.sv
`timescale 1ns / 1ps

module sie_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sie_pkg::div_ctrl_t              ctrl,
    input  logic [sie_pkg::WORD_BITS-1:0]   dividend,
    input  logic [sie_pkg::WORD_BITS-1:0]   divisor,
    output logic                            done,
    output logic [sie_pkg::WORD_BITS-1:0]   quotient
);

    localparam int W        = sie_pkg::WORD_BITS;
    localparam int CNT_BITS = $clog2(W + 1);

    logic [W:0]          rem_reg;
    logic [W:0]          rem_next;
    logic [W-1:0]        quo_reg;
    logic [W-1:0]        quo_next;
    logic [W-1:0]        dsr_reg;
    logic [W-1:0]        result_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                neg_reg;
    logic                done_reg;
    logic [W:0]          shifted;
    logic [W:0]          diff;

    // One quotient bit per cycle, restoring form on magnitudes.
    always_comb
    begin
        shifted  = {rem_reg[W-1:0], quo_reg[W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = diff[W] ? shifted : diff;
        quo_next = {quo_reg[W-2:0], ~diff[W]};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            dsr_reg <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_reg <= ctrl.negate;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (busy_reg && cnt_reg == '0)
        begin
            result_reg <= neg_reg ? (W'(0) - quo_reg) : quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(W);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = result_reg;

endmodule

>>> sv/small_integer_isa_executor_unit.sv
`timescale 1ns / 1ps

// Executes one pre-decoded instruction word at a time against a 16-entry
// register file held in a synchronous memory with two read ports. A word is
// accepted, the operands are read in the next cycle, the result is formed and
// then committed to the register file, the program counter, the cycle counter
// and the output register together, and only then is the next word accepted.
// A divide with a nonzero divisor runs the bit-serial divider, one quotient
// bit per cycle, before it commits. A result waiting at the output does not
// block the next word's execution until that word is ready to commit.
module small_integer_isa_executor_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [0:0]          mode,
    input  logic [3:0]          opcode,
    input  logic [3:0]          dest_index,
    input  logic [3:0]          src_a_index,
    input  logic [3:0]          src_b_index,
    input  logic signed [31:0]  immediate,
    input  logic [11:0]         branch_target,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [11:0]         next_pc,
    output logic [31:0]         cycle_count,
    output logic                halted,
    output logic                wrote,
    output logic [3:0]          written_index,
    output logic signed [31:0]  written_value,
    output logic                branch_taken,
    output logic                div_by_zero
);

    localparam int W  = sie_pkg::WORD_BITS;
    localparam int PB = sie_pkg::PC_BITS;
    localparam int IB = sie_pkg::IDX_IN_BITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [0:0]    mode_reg;
    logic [3:0]    op_reg;
    logic [IB-1:0] dest_reg;
    logic [W-1:0]  imm_reg;
    logic [PB-1:0] target_reg;
    logic          a_ok_reg;
    logic          b_ok_reg;
    logic          d_ok_reg;

    logic [PB-1:0] pc_reg, pc_next;
    logic [W-1:0]  cyc_reg, cyc_next;
    logic          halt_reg, halt_next;

    logic [PB-1:0] res_pc_reg, res_pc_next;
    logic [W-1:0]  res_cyc_reg, res_cyc_next;
    logic          res_halt_reg, res_halt_next;
    logic          res_wr_reg, res_wr_next;
    logic [W-1:0]  res_val_reg, res_val_next;
    logic          res_taken_reg, res_taken_next;
    logic          res_dz_reg, res_dz_next;

    logic          out_valid_reg, out_valid_next;
    logic [11:0]   out_pc_reg;
    logic [W-1:0]  out_cyc_reg;
    logic          out_halt_reg;
    logic          out_wrote_reg;
    logic [3:0]    out_idx_reg;
    logic [W-1:0]  out_val_reg;
    logic          out_taken_reg;
    logic          out_dz_reg;

    logic          accept;
    logic          commit;
    logic          cmp_dest;
    logic [W-1:0]  rd_a;
    logic [W-1:0]  rd_b;
    logic [W-1:0]  op_a;
    logic [W-1:0]  op_b;
    logic          exec;
    logic          is_arith;
    logic          is_branch;
    logic [W-1:0]  product;
    logic          do_commit_write;

    sie_pkg::div_ctrl_t div_ctrl;
    logic               div_done;
    logic [W-1:0]       div_q;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign commit   = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign cmp_dest = (opcode == sie_pkg::OP_BEQ) || (opcode == sie_pkg::OP_BNQ);
    assign do_commit_write = commit && res_wr_reg && d_ok_reg;

    sie_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (sie_pkg::REG_IDX_BITS'(src_a_index)),
        .rd_addr_b (sie_pkg::REG_IDX_BITS'(cmp_dest ? dest_index : src_b_index)),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr_en     (do_commit_write),
        .wr_addr   (sie_pkg::REG_IDX_BITS'(dest_reg)),
        .wr_data   (res_val_reg)
    );

    sie_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (op_a),
        .divisor  (op_b),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            op_reg     <= opcode;
            dest_reg   <= dest_index;
            imm_reg    <= immediate;
            target_reg <= PB'(branch_target);
            a_ok_reg   <= sie_pkg::idx_ok(src_a_index);
            b_ok_reg   <= sie_pkg::idx_ok(cmp_dest ? dest_index : src_b_index);
            d_ok_reg   <= sie_pkg::idx_ok(dest_index);
        end
    end

    // Port A carries the first source; port B the second source, or the
    // destination register when a conditional branch compares it.
    always_comb
    begin
        op_a      = a_ok_reg ? rd_a : '0;
        op_b      = b_ok_reg ? rd_b : '0;
        exec      = mode_reg[0] && !halt_reg;
        is_arith  = op_reg inside {[sie_pkg::OP_ADD : sie_pkg::OP_DIV]};
        is_branch = op_reg inside {sie_pkg::OP_B, sie_pkg::OP_BEQ, sie_pkg::OP_BNQ};
        product   = W'(op_a * op_b);

        res_pc_next    = pc_reg;
        res_cyc_next   = cyc_reg;
        res_halt_next  = halt_reg;
        res_wr_next    = 1'b0;
        res_val_next   = '0;
        res_taken_next = 1'b0;
        res_dz_next    = 1'b0;
        div_ctrl       = '{start: 1'b0, negate: op_a[W-1] ^ op_b[W-1]};

        if (!mode_reg[0])
        begin
            res_wr_next  = 1'b1;
            res_val_next = imm_reg;
        end
        else if (exec)
        begin
            if (is_arith)
            begin
                res_wr_next  = 1'b1;
                res_pc_next  = pc_reg + 1'b1;
                res_cyc_next = cyc_reg + 1'b1;
                case (op_reg)
                    sie_pkg::OP_ADD:  res_val_next = op_a + op_b;
                    sie_pkg::OP_ADDI: res_val_next = op_a + imm_reg;
                    sie_pkg::OP_SUB:  res_val_next = op_a - op_b;
                    sie_pkg::OP_MUL:  res_val_next = product;
                    default:
                    begin
                        if (op_b == '0)
                        begin
                            res_dz_next = 1'b1;
                        end
                        else
                        begin
                            div_ctrl.start = (state_reg == ST_READ);
                        end
                    end
                endcase
            end
            else if (is_branch)
            begin
                case (op_reg)
                    sie_pkg::OP_B:   res_taken_next = 1'b1;
                    sie_pkg::OP_BEQ: res_taken_next = (op_b == op_a);
                    default:         res_taken_next = (op_b != op_a);
                endcase
                res_pc_next  = res_taken_next ? target_reg : pc_reg + 1'b1;
                res_cyc_next = cyc_reg + 1'b1;
            end
            else if (op_reg == sie_pkg::OP_END)
            begin
                res_halt_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = div_ctrl.start ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            res_pc_reg    <= res_pc_next;
            res_cyc_reg   <= res_cyc_next;
            res_halt_reg  <= res_halt_next;
            res_wr_reg    <= res_wr_next;
            res_val_reg   <= res_val_next;
            res_taken_reg <= res_taken_next;
            res_dz_reg    <= res_dz_next;
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            res_val_reg <= div_q;
        end
        if (commit)
        begin
            out_pc_reg    <= 12'(res_pc_reg);
            out_cyc_reg   <= res_cyc_reg;
            out_halt_reg  <= res_halt_reg;
            out_wrote_reg <= res_wr_reg && d_ok_reg;
            out_idx_reg   <= (res_wr_reg && d_ok_reg) ? dest_reg : '0;
            out_val_reg   <= (res_wr_reg && d_ok_reg) ? res_val_reg : '0;
            out_taken_reg <= res_taken_reg;
            out_dz_reg    <= res_dz_reg;
        end
    end

    always_comb
    begin
        pc_next        = commit ? res_pc_reg : pc_reg;
        cyc_next       = commit ? res_cyc_reg : cyc_reg;
        halt_next      = commit ? res_halt_reg : halt_reg;
        out_valid_next = commit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            cyc_reg       <= W'(2);
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cyc_reg       <= cyc_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_pc       = out_pc_reg;
    assign cycle_count   = out_cyc_reg;
    assign halted        = out_halt_reg;
    assign wrote         = out_wrote_reg;
    assign written_index = out_idx_reg;
    assign written_value = out_val_reg;
    assign branch_taken  = out_taken_reg;
    assign div_by_zero   = out_dz_reg;

    // End stops the machine without moving the program or cycle counters.
    a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halt_reg) |-> $stable(pc_reg) && $stable(cyc_reg))
        else $error("halt changed the program or cycle counter");

    a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        do_commit_write |-> state_reg == ST_FIN)
        else $error("register file written outside commit");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished while no divide was pending");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_READ)
        else $error("accepted word did not go to operand read");

    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_wrote_reg |-> out_idx_reg == '0 && out_val_reg == '0)
        else $error("write fields not cleared on a word without a write");

endmodule

>>> tb/sie_exec_checker.sv
`timescale 1ns / 1ps

module sie_exec_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [0:0]         mode,
    input  logic [3:0]         opcode,
    input  logic [3:0]         dest_index,
    input  logic [3:0]         src_a_index,
    input  logic [3:0]         src_b_index,
    input  logic signed [31:0] immediate,
    input  logic [11:0]        branch_target,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [11:0]        next_pc,
    input  logic [31:0]        cycle_count,
    input  logic               halted,
    input  logic               wrote,
    input  logic [3:0]         written_index,
    input  logic signed [31:0] written_value,
    input  logic               branch_taken,
    input  logic               div_by_zero,
    output int                 error_count,
    output int                 outstanding
);

    typedef struct packed {
        logic [11:0] next_pc;
        logic [31:0] cycle_count;
        logic        halted;
        logic        wrote;
        logic [3:0]  written_index;
        logic [31:0] written_value;
        logic        branch_taken;
        logic        div_by_zero;
    } exec_result_t;

    logic [sie_pkg::WORD_BITS-1:0] reg_file [sie_pkg::REG_COUNT];
    logic [sie_pkg::PC_BITS-1:0]   pc;
    logic [31:0]                   cycles;
    logic                          halt;
    exec_result_t                  pending_results [$];

    function automatic logic [31:0] read_reg(input logic [3:0] idx);
        if (32'(idx) < sie_pkg::REG_COUNT)
        begin
            return reg_file[idx];
        end
        return '0;
    endfunction

    function automatic logic [31:0] quotient(input logic [31:0] num, input logic [31:0] den);
        logic signed [31:0] q;
        // The most negative value divided by -1 wraps back onto itself.
        if (num == 32'h8000_0000 && den == 32'hFFFF_FFFF)
        begin
            return num;
        end
        q = $signed(num) / $signed(den);
        return q;
    endfunction

    task automatic execute_word(input logic [0:0] m, input logic [3:0] op,
                                input logic [3:0] d, input logic [3:0] sa,
                                input logic [3:0] sb, input logic [31:0] imm,
                                input logic [11:0] tgt, output exec_result_t r);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] dv;
        logic [31:0] value;
        logic        do_write;
        logic        advance;
        logic        is_branch;
        logic        taken;
        logic        dz;
        a         = read_reg(sa);
        b         = read_reg(sb);
        dv        = read_reg(d);
        value     = '0;
        do_write  = 1'b0;
        advance   = 1'b0;
        is_branch = 1'b0;
        taken     = 1'b0;
        dz        = 1'b0;
        r         = '0;
        if (m == 1'b0)
        begin
            do_write = 1'b1;
            value    = imm;
        end
        else if (!halt)
        begin
            case (op)
                sie_pkg::OP_ADD:  value = a + b;
                sie_pkg::OP_ADDI: value = a + imm;
                sie_pkg::OP_SUB:  value = a - b;
                sie_pkg::OP_MUL:  value = a * b;
                sie_pkg::OP_DIV:
                begin
                    if (b == '0)
                    begin
                        dz = 1'b1;
                    end
                    else
                    begin
                        value = quotient(a, b);
                    end
                end
                sie_pkg::OP_B:    taken = 1'b1;
                sie_pkg::OP_BEQ:  taken = (dv == a);
                sie_pkg::OP_BNQ:  taken = (dv != a);
                sie_pkg::OP_END:  halt = 1'b1;
                default: ;
            endcase
            if (op == sie_pkg::OP_ADD || op == sie_pkg::OP_ADDI || op == sie_pkg::OP_SUB
                || op == sie_pkg::OP_MUL || op == sie_pkg::OP_DIV)
            begin
                do_write = 1'b1;
                advance  = 1'b1;
            end
            is_branch = (op == sie_pkg::OP_B || op == sie_pkg::OP_BEQ
                         || op == sie_pkg::OP_BNQ);
        end
        if (advance || (is_branch && !taken))
        begin
            pc = pc + 1'b1;
        end
        else if (taken)
        begin
            pc = sie_pkg::PC_BITS'(tgt);
        end
        if (advance || is_branch)
        begin
            cycles = cycles + 1;
        end
        if (do_write && 32'(d) < sie_pkg::REG_COUNT)
        begin
            reg_file[d]     = value;
            r.wrote         = 1'b1;
            r.written_index = d;
            r.written_value = value;
        end
        r.next_pc      = 12'(pc);
        r.cycle_count  = cycles;
        r.halted       = halt;
        r.branch_taken = taken;
        r.div_by_zero  = dz;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            if (error_count < 10)
            begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
            end
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        exec_result_t want;
        exec_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < sie_pkg::REG_COUNT; i++)
            begin
                reg_file[i] = '0;
            end
            pc          = '0;
            cycles      = 32'd2;
            halt        = 1'b0;
            pending_results.delete();
            error_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.next_pc       = next_pc;
                got.cycle_count   = cycle_count;
                got.halted        = halted;
                got.wrote         = wrote;
                got.written_index = written_index;
                got.written_value = written_value;
                got.branch_taken  = branch_taken;
                got.div_by_zero   = div_by_zero;
                if (pending_results.size() == 0)
                begin
                    if (error_count < 10)
                    begin
                        $display("%0t: result word with no instruction pending: %h", $time, got);
                    end
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("cycle_count", want.cycle_count, got.cycle_count);
                    check_field("halted", want.halted, got.halted);
                    check_field("wrote", want.wrote, got.wrote);
                    check_field("written_index", want.written_index, got.written_index);
                    check_field("written_value", want.written_value, got.written_value);
                    check_field("branch_taken", want.branch_taken, got.branch_taken);
                    check_field("div_by_zero", want.div_by_zero, got.div_by_zero);
                end
            end
            if (in_valid && !in_stall)
            begin
                execute_word(mode, opcode, dest_index, src_a_index, src_b_index,
                             immediate, branch_target, want);
                pending_results.insert(pending_results.size(), want);
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> tb/small_integer_isa_executor_unit_tb.sv
`timescale 1ns / 1ps

module small_integer_isa_executor_unit_tb;

    localparam logic [0:0] LOAD = 1'b0;
    localparam logic [0:0] EXEC = 1'b1;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [0:0]         mode          = '0;
    logic [3:0]         opcode        = '0;
    logic [3:0]         dest_index    = '0;
    logic [3:0]         src_a_index   = '0;
    logic [3:0]         src_b_index   = '0;
    logic signed [31:0] immediate     = '0;
    logic [11:0]        branch_target = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [11:0]        next_pc;
    logic [31:0]        cycle_count;
    logic               halted;
    logic               wrote;
    logic [3:0]         written_index;
    logic signed [31:0] written_value;
    logic               branch_taken;
    logic               div_by_zero;
    int                 error_count;
    int                 outstanding;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;

    always #5 clk = ~clk;

    small_integer_isa_executor_unit uut (
        .clk, .rst_n, .in_valid, .in_stall, .mode, .opcode, .dest_index,
        .src_a_index, .src_b_index, .immediate, .branch_target, .out_valid,
        .out_stall, .next_pc, .cycle_count, .halted, .wrote, .written_index,
        .written_value, .branch_taken, .div_by_zero
    );

    sie_exec_checker exec_check (
        .clk, .rst_n, .in_valid, .in_stall, .mode, .opcode, .dest_index,
        .src_a_index, .src_b_index, .immediate, .branch_target, .out_valid,
        .out_stall, .next_pc, .cycle_count, .halted, .wrote, .written_index,
        .written_value, .branch_taken, .div_by_zero, .error_count, .outstanding
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_word(input logic [0:0] m, input logic [3:0] op,
                             input logic [3:0] d, input logic [3:0] sa,
                             input logic [3:0] sb, input logic [31:0] imm,
                             input logic [11:0] tgt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        mode          <= m;
        opcode        <= op;
        dest_index    <= d;
        src_a_index   <= sa;
        src_b_index   <= sb;
        immediate     <= imm;
        branch_target <= tgt;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    task automatic load_reg(input logic [3:0] d, input logic [31:0] value);
        // Everything but the destination and value is ignored by a load.
        send_word(LOAD, 4'($urandom()), d, 4'($urandom()), 4'($urandom()), value,
                  12'($urandom()));
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'(int'($urandom_range(40)) - 20);
            2:
            begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return 32'($urandom_range(3));
        endcase
    endfunction

    task automatic random_words(input int count);
        int          done;
        int          pick;
        logic [3:0]  op;
        logic [3:0]  d;
        logic [3:0]  sa;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            d    = 4'($urandom());
            sa   = 4'($urandom());
            if (pick < 22)
            begin
                load_reg(d, random_value());
                done++;
            end
            else if (pick < 26)
            begin
                send_word(EXEC, 4'($urandom_range(15, 9)), d, sa, 4'($urandom()),
                          $urandom(), 12'($urandom()));
            end
            else
            begin
                // End is kept out so the program keeps running until the last phase.
                op = 4'($urandom_range(7));
                if ((op == sie_pkg::OP_BEQ || op == sie_pkg::OP_BNQ) && $urandom_range(1))
                begin
                    sa = d;
                end
                send_word(EXEC, op, d, sa, 4'($urandom()), random_value(), 12'($urandom()));
                done++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_reg(4'd1, 32'h7FFF_FFFF);
        load_reg(4'd2, 32'h8000_0000);
        load_reg(4'd3, 32'hFFFF_FFFF);
        load_reg(4'd4, 32'h0000_0001);
        load_reg(4'd15, 32'd7);
        load_reg(4'd12, 32'hFFFF_FFF9);
        load_reg(4'd13, 32'd2);
        send_word(EXEC, sie_pkg::OP_ADD, 4'd5, 4'd1, 4'd4, '0, '0);
        send_word(EXEC, sie_pkg::OP_ADDI, 4'd6, 4'd1, 4'd0, 32'h7FFF_FFFF, '0);
        send_word(EXEC, sie_pkg::OP_ADDI, 4'd0, 4'd2, 4'd0, 32'h8000_0000, '0);
        send_word(EXEC, sie_pkg::OP_SUB, 4'd7, 4'd2, 4'd4, '0, '0);
        send_word(EXEC, sie_pkg::OP_MUL, 4'd8, 4'd1, 4'd1, '0, '0);
        send_word(EXEC, sie_pkg::OP_MUL, 4'd14, 4'd2, 4'd3, '0, '0);
        send_word(EXEC, sie_pkg::OP_DIV, 4'd9, 4'd2, 4'd3, '0, '0);
        send_word(EXEC, sie_pkg::OP_DIV, 4'd10, 4'd15, 4'd0, '0, '0);
        send_word(EXEC, sie_pkg::OP_DIV, 4'd11, 4'd12, 4'd13, '0, '0);
        send_word(EXEC, sie_pkg::OP_DIV, 4'd9, 4'd15, 4'd12, '0, '0);
        // A branch to the last index makes the following add wrap the counter to zero.
        send_word(EXEC, sie_pkg::OP_B, 4'd0, 4'd0, 4'd0, '0, 12'hFFF);
        send_word(EXEC, sie_pkg::OP_ADD, 4'd5, 4'd5, 4'd4, '0, '0);
        send_word(EXEC, sie_pkg::OP_BEQ, 4'd1, 4'd1, 4'd0, '0, 12'h123);
        send_word(EXEC, sie_pkg::OP_BEQ, 4'd1, 4'd2, 4'd0, '0, 12'h456);
        send_word(EXEC, sie_pkg::OP_BNQ, 4'd1, 4'd2, 4'd0, '0, 12'hABC);
        send_word(EXEC, sie_pkg::OP_BNQ, 4'd4, 4'd4, 4'd0, '0, 12'h0F0);
        send_word(EXEC, 4'd9, 4'd3, 4'd1, 4'd2, 32'hFFFF_FFFF, 12'hFFF);
        send_word(EXEC, 4'd15, 4'd3, 4'd1, 4'd2, 32'hFFFF_FFFF, 12'hFFF);

        random_words(390);
        send_idle_pct = 69;
        random_words(390);
        send_idle_pct = 0;
        stall_pct     = 69;
        random_words(390);
        send_idle_pct = 25;
        stall_pct     = 25;
        random_words(390);

        // Once halted, only loads still change anything.
        send_word(EXEC, sie_pkg::OP_END, 4'd0, 4'd0, 4'd0, '0, '0);
        send_word(EXEC, sie_pkg::OP_ADD, 4'd1, 4'd1, 4'd4, '0, '0);
        send_word(EXEC, sie_pkg::OP_B, 4'd0, 4'd0, 4'd0, '0, 12'd100);
        load_reg(4'd0, 32'd5);
        send_word(EXEC, sie_pkg::OP_END, 4'd0, 4'd0, 4'd0, '0, '0);
        send_word(EXEC, sie_pkg::OP_BEQ, 4'd0, 4'd0, 4'd0, '0, 12'd200);

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
